### hdl/bmsw_pkg.sv
// shared types and constants for the binary morphology block
package bmsw_pkg;

	localparam int OP_W       = 2;
	localparam int SIZE_W     = 4;
	localparam int DIM_W      = 11;
	localparam int PIX_W      = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;
	localparam int FIFO_DEPTH = 16;

	typedef enum logic [OP_W-1:0] {
		OP_ERODE  = 2'd0,
		OP_DILATE = 2'd1,
		OP_OPEN   = 2'd2,
		OP_CLOSE  = 2'd3
	} op_mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_OP_MODE      = 2'd0,
		REG_WINDOW_SIZE  = 2'd1,
		REG_IMAGE_WIDTH  = 2'd2,
		REG_IMAGE_HEIGHT = 2'd3
	} cfg_reg_t;

	localparam logic [PIX_W-1:0]  WHITE_LEVEL      = 8'hFF;
	localparam logic [PIX_W-1:0]  BLACK_LEVEL      = 8'h00;
	localparam logic [SIZE_W-1:0] RST_WINDOW_SIZE  = 4'd3;
	localparam logic [DIM_W-1:0]  RST_IMAGE_WIDTH  = 11'd640;
	localparam logic [DIM_W-1:0]  RST_IMAGE_HEIGHT = 11'd480;

	typedef struct packed {
		logic res;
		logic last;
	} result_t;

endpackage

### hdl/bmsw_window_stage.sv
// one square window stage: column line store, window shift register and erode/dilate reduce
module bmsw_window_stage #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024,
	parameter int MAX_WINDOW = 15,
	parameter int TAG_W      = 1,
	localparam int XW  = $clog2(MAX_WIDTH),
	localparam int WW  = $clog2(MAX_WIDTH + 1),
	localparam int HW  = $clog2(MAX_HEIGHT + 1),
	localparam int YW  = $clog2(MAX_HEIGHT + MAX_WINDOW + 1),
	localparam int RW  = $clog2(MAX_WINDOW / 2 + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_act,
	input  logic             in_bit,
	input  logic [XW-1:0]    in_col,
	input  logic [XW-1:0]    in_cx,
	input  logic [YW-1:0]    in_cy,
	input  logic [TAG_W-1:0] in_tag,
	input  logic [WW-1:0]    width,
	input  logic [HW-1:0]    height,
	input  logic [RW-1:0]    radius,
	input  logic             erode,
	output logic             out_valid,
	output logic             out_res,
	output logic [TAG_W-1:0] out_tag
);

	localparam int MW  = MAX_WINDOW;
	localparam int HL  = MAX_WINDOW - 1;
	localparam int CXW = XW + 2;
	localparam int CYW = YW + 1;

	logic [HL-1:0] lines_mem [MAX_WIDTH];

	logic             valid_s1, act_s1, bit_s1, erode_s1;
	logic [XW-1:0]    col_s1, cx_s1;
	logic [YW-1:0]    cy_s1;
	logic [TAG_W-1:0] tag_s1;
	logic [HL-1:0]    rd_s1, fwd_data_s1;
	logic             fwd_s1;

	logic             wr_en;
	logic [HL-1:0]    hist, wr_data;

	logic [MW-1:0]    win_q [MW];

	logic [CXW-1:0]   tx, two_r_x;
	logic [CYW-1:0]   ty, two_r_y;
	logic [MW-1:0]    col_mask, row_mask;
	logic             all_in;

	logic             valid_s2, erode_s2, all_in_s2;
	logic [MW-1:0]    col_mask_s2, row_mask_s2;
	logic [TAG_W-1:0] tag_s2;
	logic             any_hit, all_hit, res;

	logic             valid_s3, res_s3;
	logic [TAG_W-1:0] tag_s3;

	assign hist    = fwd_s1 ? fwd_data_s1 : rd_s1;
	assign wr_en   = valid_s1 && act_s1;
	assign wr_data = {hist[HL-2:0], bit_s1};

	// line store, read-old with forwarding of the write in flight
	always_ff @(posedge clk) begin
		if (wr_en) begin
			lines_mem[col_s1] <= wr_data;
		end
		rd_s1       <= lines_mem[in_col];
		fwd_s1      <= wr_en && (col_s1 == in_col);
		fwd_data_s1 <= wr_data;
		act_s1      <= in_act;
		bit_s1      <= in_bit;
		col_s1      <= in_col;
		cx_s1       <= in_cx;
		cy_s1       <= in_cy;
		tag_s1      <= in_tag;
		erode_s1    <= erode;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			for (int j = 0; j < MW; j++) begin
				win_q[j] <= '0;
			end
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			if (wr_en) begin
				win_q[0] <= {hist, bit_s1};
				for (int j = 1; j < MW; j++) begin
					win_q[j] <= win_q[j-1];
				end
			end
		end
	end

	// column j holds x = cx + r - j, bit k holds y = cy + r - k
	always_comb begin
		tx      = CXW'(cx_s1) + CXW'(radius);
		ty      = CYW'(cy_s1) + CYW'(radius);
		two_r_x = CXW'(radius) << 1;
		two_r_y = CYW'(radius) << 1;
		for (int j = 0; j < MW; j++) begin
			col_mask[j] = (CXW'(j) <= two_r_x) && (tx >= CXW'(j))
				&& ((tx - CXW'(j)) < CXW'(width));
			row_mask[j] = (CYW'(j) <= two_r_y) && (ty >= CYW'(j))
				&& ((ty - CYW'(j)) < CYW'(height));
		end
		all_in = (CXW'(cx_s1) >= CXW'(radius)) && (tx < CXW'(width))
			&& (CYW'(cy_s1) >= CYW'(radius)) && (ty < CYW'(height));
	end

	always_ff @(posedge clk) begin
		col_mask_s2 <= col_mask;
		row_mask_s2 <= row_mask;
		all_in_s2   <= all_in;
		erode_s2    <= erode_s1;
		tag_s2      <= tag_s1;
	end

	always_comb begin
		any_hit = 1'b0;
		all_hit = 1'b1;
		for (int j = 0; j < MW; j++) begin
			for (int k = 0; k < MW; k++) begin
				if (col_mask_s2[j] && row_mask_s2[k]) begin
					any_hit = any_hit | win_q[j][k];
					all_hit = all_hit & win_q[j][k];
				end
			end
		end
		res = erode_s2 ? (all_in_s2 && all_hit) : any_hit;
	end

	always_ff @(posedge clk) begin
		res_s3 <= res;
		tag_s3 <= tag_s2;
	end

	assign out_valid = valid_s3;
	assign out_res   = res_s3;
	assign out_tag   = tag_s3;

endmodule

### hdl/binary_morphology_square_window.sv
// top level: position counters, two window stages and the result queue
// Binary erode, dilate, open or close over a square window, one pixel per clock.
// Input channel: in_valid / in_stall with kind (0 pixel, 1 flush) and pixel_value;
// a pixel is white only at 255. Send the W*H pixels of a frame in raster order,
// then flush transactions to push out the last rows: erode and dilate need
// r*W + r of them, open and close twice that, r = (window_size-1)/2.
// Flush transactions while frame pixels are still due are taken and dropped.
// Output channel: out_valid / out_stall with out_pixel (0 or 255) and
// frame_last on the final pixel of the frame.
// Throughput is one transaction per clock while in_stall is low. A result leaves
// the pipeline via the input register and the registers of both window stages,
// after the transaction that completes its window; the line stores in the fixed
// register chain are single port-pair memories of MAX_WIDTH columns.
// When the receiver stalls, results collect in a 16-entry queue; the input
// stalls only when the queue and the pipeline together could overflow it.
// Reset returns the registers to erode, size 3, 640 x 480 and the frame
// position to zero; the line stores need no clearing.
// Configuration is written through cfg_wen / cfg_index / cfg_data while idle.
module binary_morphology_square_window #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024,
	parameter int MAX_WINDOW = 15
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wen,
	input  logic [bmsw_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bmsw_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            kind,
	input  logic [bmsw_pkg::PIX_W-1:0]      pixel_value,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [bmsw_pkg::PIX_W-1:0]      out_pixel,
	output logic                            frame_last
);

	import bmsw_pkg::*;

	localparam int XW  = $clog2(MAX_WIDTH);
	localparam int WW  = $clog2(MAX_WIDTH + 1);
	localparam int HW  = $clog2(MAX_HEIGHT + 1);
	localparam int YW  = $clog2(MAX_HEIGHT + MAX_WINDOW + 1);
	localparam int RW  = $clog2(MAX_WINDOW / 2 + 1);
	localparam int SZW = $clog2(MAX_WINDOW + 1);
	localparam int PW  = $clog2(MAX_WIDTH * MAX_HEIGHT + 2 * MAX_WINDOW * (MAX_WIDTH + 1) + 1);
	localparam int FPW = $clog2(FIFO_DEPTH);
	localparam int FCW = $clog2(FIFO_DEPTH + 1);

	typedef struct packed {
		logic [XW-1:0] qx;
		logic [XW-1:0] ox;
		logic [YW-1:0] oy;
		logic          q_on;
		logic          emit1;
		logic          last1;
		logic          emit2;
		logic          last2;
	} tag1_t;

	typedef struct packed {
		logic res1;
		logic emit1;
		logic last1;
		logic emit2;
		logic last2;
	} tag2_t;

	op_mode_t          op_mode_q;
	logic [SIZE_W-1:0] size_q;
	logic [DIM_W-1:0]  width_q, height_q;

	logic [WW-1:0]     w_eff;
	logic [HW-1:0]     h_eff;
	logic [SZW-1:0]    size_eff;
	logic [RW-1:0]     radius;
	logic [PW-1:0]     n_pix, lag1, lag2, frame_end;
	logic              two_stage;

	logic [PW-1:0]     p_q, p_next;
	logic [XW-1:0]     px_q, qx_q, ox_q;
	logic [YW-1:0]     qy_q, oy_q;
	logic              q_on, o_on, in_pix, drop_in, take, wrap;
	logic              px_end, qx_end, ox_end;

	logic              valid_s0, bit_s0;
	logic [XW-1:0]     px_s0, qx_s0;
	logic [YW-1:0]     qy_s0;
	tag1_t             tag1_s0;

	logic              st1_valid, st1_res;
	tag1_t             st1_tag;
	tag2_t             st2_in_tag, st2_tag;
	logic              st2_valid, st2_res;

	logic              emit, push, pop, drain;
	result_t           push_data;
	result_t           fifo_q [FIFO_DEPTH];
	logic [FPW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [FCW-1:0]    fcnt_q, cnt_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_mode_q <= OP_ERODE;
			size_q    <= RST_WINDOW_SIZE;
			width_q   <= RST_IMAGE_WIDTH;
			height_q  <= RST_IMAGE_HEIGHT;
		end else if (cfg_wen) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_OP_MODE:      op_mode_q <= op_mode_t'(cfg_data[OP_W-1:0]);
				REG_WINDOW_SIZE:  size_q    <= cfg_data[SIZE_W-1:0];
				REG_IMAGE_WIDTH:  width_q   <= cfg_data[DIM_W-1:0];
				REG_IMAGE_HEIGHT: height_q  <= cfg_data[DIM_W-1:0];
			endcase
		end
	end

	always_comb begin
		if (width_q == '0) begin
			w_eff = WW'(1);
		end else if (32'(width_q) > MAX_WIDTH) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(width_q);
		end
		if (height_q == '0) begin
			h_eff = HW'(1);
		end else if (32'(height_q) > MAX_HEIGHT) begin
			h_eff = HW'(MAX_HEIGHT);
		end else begin
			h_eff = HW'(height_q);
		end
		if (32'(size_q) > MAX_WINDOW) begin
			size_eff = SZW'(MAX_WINDOW);
		end else begin
			size_eff = SZW'(size_q);
		end
		radius    = (size_eff == '0) ? '0 : RW'((size_eff - 1'b1) >> 1);
		two_stage = (op_mode_q == OP_OPEN) || (op_mode_q == OP_CLOSE);
		n_pix     = PW'(w_eff) * PW'(h_eff);
		lag1      = PW'(radius) * PW'(w_eff) + PW'(radius);
		lag2      = lag1 << 1;
		frame_end = n_pix + (two_stage ? lag2 : lag1);
	end

	// stream position and the centres of both stages
	assign q_on    = p_q >= lag1;
	assign o_on    = p_q >= lag2;
	assign in_pix  = p_q < n_pix;
	assign drop_in = in_pix && kind;
	assign take    = in_valid && !in_stall && !drop_in;
	assign p_next  = p_q + 1'b1;
	assign wrap    = p_next >= frame_end;
	assign px_end  = ((XW + 1)'(px_q) + 1'b1) == (XW + 1)'(w_eff);
	assign qx_end  = ((XW + 1)'(qx_q) + 1'b1) == (XW + 1)'(w_eff);
	assign ox_end  = ((XW + 1)'(ox_q) + 1'b1) == (XW + 1)'(w_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q  <= '0;
			px_q <= '0;
			qx_q <= '0;
			qy_q <= '0;
			ox_q <= '0;
			oy_q <= '0;
		end else if (take) begin
			if (wrap) begin
				p_q  <= '0;
				px_q <= '0;
				qx_q <= '0;
				qy_q <= '0;
				ox_q <= '0;
				oy_q <= '0;
			end else begin
				p_q  <= p_next;
				px_q <= px_end ? '0 : px_q + 1'b1;
				if (q_on) begin
					qx_q <= qx_end ? '0 : qx_q + 1'b1;
					qy_q <= qx_end ? qy_q + 1'b1 : qy_q;
				end
				if (o_on) begin
					ox_q <= ox_end ? '0 : ox_q + 1'b1;
					oy_q <= ox_end ? oy_q + 1'b1 : oy_q;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s0 <= 1'b0;
		end else begin
			valid_s0 <= take;
		end
	end

	always_ff @(posedge clk) begin
		bit_s0        <= in_pix && !kind && (pixel_value == WHITE_LEVEL);
		px_s0         <= px_q;
		qx_s0         <= qx_q;
		qy_s0         <= qy_q;
		tag1_s0.qx    <= qx_q;
		tag1_s0.ox    <= ox_q;
		tag1_s0.oy    <= oy_q;
		tag1_s0.q_on  <= q_on;
		tag1_s0.emit1 <= q_on && (qy_q < YW'(h_eff));
		tag1_s0.last1 <= (qx_q == XW'(w_eff - 1'b1)) && (qy_q == YW'(h_eff - 1'b1));
		tag1_s0.emit2 <= o_on && (oy_q < YW'(h_eff));
		tag1_s0.last2 <= (ox_q == XW'(w_eff - 1'b1)) && (oy_q == YW'(h_eff - 1'b1));
	end

	bmsw_window_stage #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.MAX_WINDOW (MAX_WINDOW),
		.TAG_W      ($bits(tag1_t))
	) u_stage1 (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s0),
		.in_act    (1'b1),
		.in_bit    (bit_s0),
		.in_col    (px_s0),
		.in_cx     (qx_s0),
		.in_cy     (qy_s0),
		.in_tag    (tag1_s0),
		.width     (w_eff),
		.height    (h_eff),
		.radius    (radius),
		.erode     ((op_mode_q == OP_ERODE) || (op_mode_q == OP_OPEN)),
		.out_valid (st1_valid),
		.out_res   (st1_res),
		.out_tag   (st1_tag)
	);

	assign st2_in_tag.res1  = st1_res;
	assign st2_in_tag.emit1 = st1_tag.emit1;
	assign st2_in_tag.last1 = st1_tag.last1;
	assign st2_in_tag.emit2 = st1_tag.emit2;
	assign st2_in_tag.last2 = st1_tag.last2;

	bmsw_window_stage #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.MAX_WINDOW (MAX_WINDOW),
		.TAG_W      ($bits(tag2_t))
	) u_stage2 (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (st1_valid),
		.in_act    (st1_tag.q_on),
		.in_bit    (st1_res),
		.in_col    (st1_tag.qx),
		.in_cx     (st1_tag.ox),
		.in_cy     (st1_tag.oy),
		.in_tag    (st2_in_tag),
		.width     (w_eff),
		.height    (h_eff),
		.radius    (radius),
		.erode     (op_mode_q == OP_CLOSE),
		.out_valid (st2_valid),
		.out_res   (st2_res),
		.out_tag   (st2_tag)
	);

	// result queue
	assign emit           = two_stage ? st2_tag.emit2 : st2_tag.emit1;
	assign push           = st2_valid && emit;
	assign drain          = st2_valid && !emit;
	assign push_data.res  = two_stage ? st2_res : st2_tag.res1;
	assign push_data.last = two_stage ? st2_tag.last2 : st2_tag.last1;
	assign pop            = out_valid && !out_stall;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fcnt_q   <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			fcnt_q <= fcnt_q + FCW'(push) - FCW'(pop);
			cnt_q  <= cnt_q + FCW'(take) - FCW'(pop) - FCW'(drain);
		end
	end

	assign in_stall   = cnt_q >= FCW'(FIFO_DEPTH);
	assign out_valid  = fcnt_q != '0;
	assign out_pixel  = fifo_q[rd_ptr_q].res ? WHITE_LEVEL : BLACK_LEVEL;
	assign frame_last = fifo_q[rd_ptr_q].last;

	a_queue_room: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |-> (fcnt_q < FCW'(FIFO_DEPTH)))
		else $error("result queue overflow");

	a_credit_cover: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q >= fcnt_q)
		else $error("credit count below queue fill");

	a_binary_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((out_pixel == WHITE_LEVEL) || (out_pixel == BLACK_LEVEL)))
		else $error("non-binary result pixel");

endmodule
